// ===== sv/crt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants for the coefficient rejection test.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int COEFF_WIDTH_DEF = 24;
    localparam int REG_WIDTH       = 21;
    localparam int RAND_WIDTH      = 24;
    localparam int CFG_IDX_WIDTH   = 1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_GAMMA = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BETA  = 1'd1;

    localparam logic [REG_WIDTH-1:0] GAMMA_RESET = 21'd4096;
    localparam logic [REG_WIDTH-1:0] BETA_RESET  = 21'd58;

    // verdict of one coefficient test
    typedef struct packed {
        logic used;
        logic reject;
    } crt_verdict_t;

endpackage
`default_nettype wire

// ===== sv/crt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crt_in_if / crt_out_if
// Valid/ready channels carrying coefficient words and verdict words.
// ----------------------------------------------------------------------------
interface crt_in_if #(
    parameter int COEFF_WIDTH = crt_pkg::COEFF_WIDTH_DEF
);
    import crt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COEFF_WIDTH-1:0] z_coeff;
    logic [COEFF_WIDTH-1:0] v_coeff;
    logic [RAND_WIDTH-1:0]  random_word;
    logic                   last_coeff;

    modport source (output valid, z_coeff, v_coeff, random_word, last_coeff, input ready);
    modport sink   (input valid, z_coeff, v_coeff, random_word, last_coeff, output ready);
endinterface

interface crt_out_if;
    logic valid;
    logic ready;
    logic random_used;
    logic coeff_reject;
    logic poly_reject;
    logic last;

    modport source (output valid, random_used, coeff_reject, poly_reject, last, input ready);
    modport sink   (input valid, random_used, coeff_reject, poly_reject, last, output ready);
endinterface
`default_nettype wire

// ===== sv/crt_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crt_eval
// Combinational test of one coefficient: window checks, one multiply, compare.
// ----------------------------------------------------------------------------
module crt_eval #(
    parameter int COEFF_WIDTH = crt_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic [crt_pkg::REG_WIDTH-1:0]  gamma_bound,
    input  wire logic [crt_pkg::REG_WIDTH-1:0]  beta_margin,
    input  wire logic [COEFF_WIDTH-1:0]         z_coeff,
    input  wire logic [COEFF_WIDTH-1:0]         v_coeff,
    input  wire logic [crt_pkg::RAND_WIDTH-1:0] random_word,
    output crt_pkg::crt_verdict_t               verdict
);
    import crt_pkg::*;

    localparam int MW = (COEFF_WIDTH > REG_WIDTH) ? COEFF_WIDTH : REG_WIDTH;
    localparam int FW = MW + 2;
    localparam int PW = RAND_WIDTH + 1 + FW;
    localparam int LIM_SHIFT = RAND_WIDTH + 1;

    logic [COEFF_WIDTH-1:0] a, b;
    logic [MW:0]            a_w, b_w, g_w, bt_w;
    logic                   fast, over, low_mag;

    logic signed [FW-1:0] g_s, bt_s, a_s, b_s, m_s, d_s;
    logic signed [FW-1:0] f1, t1, t2, t1c, t2c, f2, factor, lim_base;
    logic signed [PW-1:0] lim_p, prod;

    always_comb
    begin
        a = z_coeff[COEFF_WIDTH-1] ? (~z_coeff + 1'b1) : z_coeff;
        b = v_coeff[COEFF_WIDTH-1] ? (~v_coeff + 1'b1) : v_coeff;

        a_w  = (MW+1)'(a);
        b_w  = (MW+1)'(b);
        g_w  = (MW+1)'(gamma_bound);
        bt_w = (MW+1)'(beta_margin);

        fast    = (a_w >= bt_w) && ((a_w + bt_w) < g_w);
        over    = (a_w >= g_w);
        low_mag = (a_w < bt_w);

        g_s  = $signed(FW'(g_w));
        bt_s = $signed(FW'(bt_w));
        a_s  = $signed(FW'(a_w));
        b_s  = $signed(FW'(b_w));
        m_s  = (a_w > b_w) ? a_s : b_s;
        d_s  = (a_w > b_w) ? (a_s - b_s) : (b_s - a_s);

        // small-magnitude branch
        f1 = (g_s - m_s) <<< 1;

        // general branch
        t1  = g_s - d_s;
        t2  = g_s - a_s - b_s;
        t1c = t1[FW-1] ? '0 : t1;
        t2c = t2[FW-1] ? '0 : t2;
        f2  = t1c + t2c;

        factor   = low_mag ? f1 : f2;
        lim_base = low_mag ? (g_s - bt_s) : (g_s - a_s);
        lim_p    = PW'(lim_base) <<< LIM_SHIFT;

        prod = PW'($signed({1'b0, random_word})) * PW'(factor);

        verdict.used   = !fast && !over;
        verdict.reject = over || (!fast && (prod > lim_p));
    end

endmodule
`default_nettype wire

// ===== sv/coeff_rejection_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coeff_rejection_test
// Per-coefficient rejection test with sticky polynomial reject flag.
// ----------------------------------------------------------------------------
// One coefficient word per clock, sustained while verdicts are taken. Each
// word is captured in an input register, tested combinationally (abs,
// window compares, one 25-bit by (max(COEFF_WIDTH,21)+2)-bit signed multiply
// and compare) and loaded into the verdict register, from which the verdict
// word is presented. The input is ready unless the input register holds a
// word while the verdict register is full and stalled. random_used tells
// the upstream whether random_word was consumed. poly_reject is the OR of
// rejects since the last word flagged last_coeff; on a word with last set
// it is the set's verdict, and the flag then clears. gamma_bound (index 0)
// and beta_margin (index 1) must be written while idle; no check enforces it.
// ----------------------------------------------------------------------------
module coeff_rejection_test #(
    parameter int COEFF_WIDTH = crt_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [crt_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [crt_pkg::REG_WIDTH-1:0]     cfg_wdata,
    crt_in_if.sink                                 coeff,
    crt_out_if.source                              verdict
);
    import crt_pkg::*;

    logic [REG_WIDTH-1:0]   gamma_reg, beta_reg;

    logic                   s1_valid_reg, s1_valid_next;
    logic [COEFF_WIDTH-1:0] s1_z_reg, s1_v_reg;
    logic [RAND_WIDTH-1:0]  s1_r_reg;
    logic                   s1_last_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_used_reg, out_rej_reg, out_poly_reg, out_last_reg;
    logic                   reject_seen_reg, reject_seen_next;

    logic                   out_free, advance, in_take, poly;
    crt_verdict_t           res;

    crt_eval #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_eval (
        .gamma_bound (gamma_reg),
        .beta_margin (beta_reg),
        .z_coeff     (s1_z_reg),
        .v_coeff     (s1_v_reg),
        .random_word (s1_r_reg),
        .verdict     (res)
    );

    always_comb
    begin
        out_free    = !out_valid_reg || verdict.ready;
        advance     = s1_valid_reg && out_free;
        coeff.ready = !s1_valid_reg || out_free;
        in_take     = coeff.valid && coeff.ready;
        poly        = reject_seen_reg || res.reject;

        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (verdict.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (advance)
            reject_seen_next = s1_last_reg ? 1'b0 : poly;
        else
            reject_seen_next = reject_seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg       <= GAMMA_RESET;
            beta_reg        <= BETA_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            reject_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAMMA: gamma_reg <= cfg_wdata;
                    CFG_BETA:  beta_reg  <= cfg_wdata;
                    default:   ;
                endcase
            end
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            reject_seen_reg <= reject_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_z_reg    <= coeff.z_coeff;
            s1_v_reg    <= coeff.v_coeff;
            s1_r_reg    <= coeff.random_word;
            s1_last_reg <= coeff.last_coeff;
        end
        if (advance)
        begin
            out_used_reg <= res.used;
            out_rej_reg  <= res.reject;
            out_poly_reg <= poly;
            out_last_reg <= s1_last_reg;
        end
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.random_used  = out_used_reg;
    assign verdict.coeff_reject = out_rej_reg;
    assign verdict.poly_reject  = out_poly_reg;
    assign verdict.last         = out_last_reg;

endmodule
`default_nettype wire

// ===== verif/crt_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// crt_verdict_checker
// Watches the coefficient and verdict channels and the register port, keeps
// its own gamma/beta copy and sticky reject flag, predicts the verdict word
// of every accepted coefficient word and compares it in order with what the
// block returns.
// ----------------------------------------------------------------------------
module crt_verdict_checker #(
    parameter int CW = crt_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [crt_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [crt_pkg::REG_WIDTH-1:0]     cfg_wdata,
    crt_in_if                                      coeff,
    crt_out_if                                     verdict,
    output int                                     failures,
    output int                                     pending,
    output int                                     checked,
    output int                                     used_count,
    output int                                     reject_count
);
    import crt_pkg::*;

    localparam longint RAND_SPAN = longint'(1) << RAND_WIDTH;

    typedef struct packed {
        crt_verdict_t verdict;
        logic         poly;
        logic         last;
    } verdict_word_t;

    verdict_word_t            awaited_verdicts[$];
    logic [REG_WIDTH-1:0]     gamma_q;
    logic [REG_WIDTH-1:0]     beta_q;
    logic                     reject_seen;

    function automatic longint abs_coeff(logic [CW-1:0] c);
        logic [CW-1:0] u;
        longint        m;
        u = c[CW-1] ? -c : c;
        m = longint'(u);
        return m;
    endfunction

    function automatic longint clip_zero(longint x);
        return (x > 0) ? x : 0;
    endfunction

    function automatic crt_verdict_t judge_coeff(logic [CW-1:0] z, logic [CW-1:0] v,
                                                 logic [RAND_WIDTH-1:0] r,
                                                 logic [REG_WIDTH-1:0] gamma,
                                                 logic [REG_WIDTH-1:0] beta);
        longint       a, b, g, bt, rv, f, lim, hi, spread;
        crt_verdict_t res;
        a  = abs_coeff(z);
        b  = abs_coeff(v);
        g  = longint'(gamma);
        bt = longint'(beta);
        rv = longint'(r);
        res.used   = 1'b0;
        res.reject = 1'b0;
        if (!(a >= bt && a < g - bt)) begin
            if (a >= g) begin
                res.reject = 1'b1;
            end
            else begin
                res.used = 1'b1;
                hi = (a > b) ? a : b;
                if (a < bt) begin
                    f   = 2 * g - 2 * hi;
                    lim = 2 * (g - bt) * RAND_SPAN;
                end
                else begin
                    spread = (a > b) ? a - b : b - a;
                    f      = clip_zero(g - spread) + clip_zero(g - a - b);
                    lim    = 2 * clip_zero(g - ((a > bt) ? a : bt)) * RAND_SPAN;
                end
                res.reject = (rv * f > lim);
            end
        end
        return res;
    endfunction

    task automatic check_bit(string name, logic exp_v, logic got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0b, got %0b", name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        verdict_word_t exp_w;
        verdict_word_t new_w;
        if (!rst_n) begin
            awaited_verdicts.delete();
            gamma_q      = GAMMA_RESET;
            beta_q       = BETA_RESET;
            reject_seen  = 1'b0;
            failures     = 0;
            pending      = 0;
            checked      = 0;
            used_count   = 0;
            reject_count = 0;
        end
        else begin
            if (verdict.valid && verdict.ready) begin
                checked++;
                if (awaited_verdicts.size() == 0) begin
                    $error("verdict word with nothing expected");
                    failures++;
                end
                else begin
                    exp_w = awaited_verdicts.pop_front();
                    check_bit("random_used", exp_w.verdict.used, verdict.random_used);
                    check_bit("coeff_reject", exp_w.verdict.reject, verdict.coeff_reject);
                    check_bit("poly_reject", exp_w.poly, verdict.poly_reject);
                    check_bit("last", exp_w.last, verdict.last);
                end
            end
            if (coeff.valid && coeff.ready) begin
                new_w.verdict = judge_coeff(coeff.z_coeff, coeff.v_coeff, coeff.random_word,
                                            gamma_q, beta_q);
                new_w.poly    = reject_seen | new_w.verdict.reject;
                new_w.last    = coeff.last_coeff;
                reject_seen   = new_w.last ? 1'b0 : new_w.poly;
                used_count   += int'(new_w.verdict.used);
                reject_count += int'(new_w.verdict.reject);
                awaited_verdicts.push_back(new_w);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GAMMA: gamma_q = cfg_wdata;
                    CFG_BETA:  beta_q  = cfg_wdata;
                    default:   ;
                endcase
            end
            pending = awaited_verdicts.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for coeff_rejection_test. A directed burst hits the
// window edges, sign extremes and the large-companion case; then random
// polynomial sets run under a dozen gamma/beta settings with random gaps on
// both channels, one long output stall and one full drain mid-phase.
// Prediction and comparison live in crt_verdict_checker.
// ----------------------------------------------------------------------------
module tb;
    import crt_pkg::*;

    localparam int     CW          = COEFF_WIDTH_DEF;
    localparam longint MAG_MAX     = longint'(1) << (CW - 1);
    localparam int     N_PHASES    = 12;
    localparam int     PHASE_ITEMS = 128;
    localparam int     HOLD_CYCLES = 300;
    localparam int     SETTLE      = 4;
    localparam int     LIMIT       = 2000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [REG_WIDTH-1:0]     cfg_wdata;

    crt_in_if #(.COEFF_WIDTH(CW)) coeff_ch ();
    crt_out_if                    verdict_ch ();

    int     failures, pending, checked, used_count, reject_count;
    int     n_sent;
    bit     tx_idle, rx_idle, long_hold;
    longint cur_gamma, cur_beta;

    coeff_rejection_test #(.COEFF_WIDTH(CW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coeff     (coeff_ch),
        .verdict   (verdict_ch)
    );

    crt_verdict_checker #(.CW(CW)) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .coeff        (coeff_ch),
        .verdict      (verdict_ch),
        .failures     (failures),
        .pending      (pending),
        .checked      (checked),
        .used_count   (used_count),
        .reject_count (reject_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // magnitude aimed at one of the decision regions of the current setting
    function automatic longint pick_magnitude();
        longint lo, hi;
        lo = 0;
        hi = MAG_MAX;
        case ($urandom_range(0, 6))
            0: begin lo = cur_beta;      hi = cur_gamma - cur_beta - 1; end
            1: begin lo = 0;             hi = cur_beta - 1;             end
            2: begin lo = cur_gamma - cur_beta; hi = cur_gamma - 1;     end
            3: begin lo = cur_gamma;     hi = cur_gamma + 16;           end
            4: ;
            5: begin lo = cur_gamma - 4; hi = cur_gamma + 4;            end
            default: begin lo = cur_beta - 2; hi = cur_beta + 2;        end
        endcase
        if (lo < 0) lo = 0;
        if (hi > MAG_MAX) hi = MAG_MAX;
        if (lo > hi)
        begin
            lo = 0;
            hi = MAG_MAX;
        end
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic logic [CW-1:0] make_coeff(longint m);
        logic [CW-1:0] c;
        c = m[CW-1:0];
        if (m == MAG_MAX || $urandom_range(0, 1) == 1) c = -c;
        return c;
    endfunction

    function automatic logic [RAND_WIDTH-1:0] pick_random_word();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return '0;
        if (p < 10) return '1;
        return RAND_WIDTH'($urandom);
    endfunction

    task automatic send_word(input logic [CW-1:0] z, input logic [CW-1:0] v,
                             input logic [RAND_WIDTH-1:0] r, input logic last);
        int gap;
        coeff_ch.valid       <= 1'b1;
        coeff_ch.z_coeff     <= z;
        coeff_ch.v_coeff     <= v;
        coeff_ch.random_word <= r;
        coeff_ch.last_coeff  <= last;
        @(posedge clk);
        while (coeff_ch.ready !== 1'b1) @(posedge clk);
        n_sent++;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            coeff_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every verdict word is back
    task automatic settle();
        coeff_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(input logic [REG_WIDTH-1:0] g, input logic [REG_WIDTH-1:0] b);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAMMA;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_index <= CFG_BETA;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_gamma = longint'(g);
        cur_beta  = longint'(b);
    endtask

    task automatic run_phase(input int count, input bit pause_mid);
        int             left, len, k;
        longint         am, bm;
        logic [CW-1:0]  z, v;
        logic           last;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 24);
            if (len > left) len = left;
            for (k = 0; k < len; k++)
            begin
                if (pause_mid && left == count / 2) settle();
                if ($urandom_range(0, 9) == 0)
                begin
                    z    = CW'($urandom);
                    v    = CW'($urandom);
                    last = 1'($urandom_range(0, 1));
                end
                else
                begin
                    am   = pick_magnitude();
                    bm   = ($urandom_range(0, 4) == 0) ? am : pick_magnitude();
                    z    = make_coeff(am);
                    v    = make_coeff(bm);
                    last = (k == len - 1);
                end
                send_word(z, v, pick_random_word(), last);
                left--;
            end
        end
    endtask

    // output side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        bit hold_done;
        stall            = 0;
        hold_done        = 1'b0;
        verdict_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                stall--;
                verdict_ch.ready <= 1'b0;
            end
            else
            begin
                verdict_ch.ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 30) stall = pick_gap();
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    initial
    begin
        int idle;
        idle = 0;
        while (idle < LIMIT)
        begin
            @(posedge clk);
            if ((coeff_ch.valid && coeff_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("[coeff_rejection_test] ERROR");
        $finish;
    end

    initial
    begin
        logic [REG_WIDTH-1:0] g_set, b_set;
        int                   p;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_GAMMA;
        cfg_wdata            = '0;
        coeff_ch.valid       = 1'b0;
        coeff_ch.z_coeff     = '0;
        coeff_ch.v_coeff     = '0;
        coeff_ch.random_word = '0;
        coeff_ch.last_coeff  = 1'b0;
        long_hold            = 1'b0;
        tx_idle              = 1'b1;
        rx_idle              = 1'b1;
        n_sent               = 0;
        cur_gamma            = longint'(GAMMA_RESET);
        cur_beta             = longint'(BETA_RESET);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset setting (gamma 4096, beta 58)
        send_word(0, 0, 24'h000000, 1'b0);
        send_word(0, 0, 24'hFFFFFF, 1'b0);
        send_word(57, 57, 24'h123456, 1'b0);
        send_word(58, 0, 24'h000000, 1'b0);
        send_word(-4037, 100, 24'hFFFFFF, 1'b0);
        send_word(4038, 4038, 24'hFFFFFF, 1'b0);
        send_word(-4095, 0, 24'h000001, 1'b0);
        send_word(4096, 0, 24'h000000, 1'b1);
        send_word(8388607, -8388608, 24'hFFFFFF, 1'b0);
        send_word(-8388608, 8388607, 24'h000000, 1'b1);
        send_word(10, 5000, 24'hFFFFFF, 1'b0);
        send_word(10, -8388608, 24'hFFFFFF, 1'b0);
        send_word(-3, 4095, 24'h000001, 1'b1);
        send_word(4050, -10, 24'hFFFFFF, 1'b0);
        send_word(4050, 4050, 24'h800000, 1'b0);
        send_word(100, 3000, 24'h555555, 1'b0);
        send_word(0, 1, 24'hAAAAAA, 1'b1);
        send_word(-1, -1, 24'h000000, 1'b0);
        send_word(57, -4096, 24'hFFFFFF, 1'b1);

        for (p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1:  begin g_set = 21'd131072;  b_set = 21'd78;      end
                    2:  begin g_set = 21'd524288;  b_set = 21'd120;     end
                    3:  begin g_set = 21'd1;       b_set = 21'd0;       end
                    4:  begin g_set = 21'd0;       b_set = 21'd0;       end
                    5:  begin g_set = 21'd1048576; b_set = 21'd0;       end
                    6:  begin g_set = 21'd1048576; b_set = 21'd1048576; end
                    7:  begin g_set = 21'd100;     b_set = 21'd60;      end
                    8:  begin g_set = '1;          b_set = '1;          end
                    11:
                    begin
                        g_set = REG_WIDTH'($urandom);
                        b_set = REG_WIDTH'($urandom);
                    end
                    default:
                    begin
                        g_set = REG_WIDTH'($urandom_range(1, 1048576));
                        b_set = REG_WIDTH'($urandom_range(0, g_set / 4 + 1));
                    end
                endcase
                write_config(g_set, b_set);
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (p == 2)
            begin
                tx_idle   = 1'b0;
                long_hold = 1'b1;
            end
            run_phase(PHASE_ITEMS, p == 5);
        end
        settle();

        $display("%0d coefficient words over %0d gamma/beta settings, %0d verdicts checked",
                 n_sent, N_PHASES, checked);
        $display("%0d words consumed the random word, %0d rejected on their own",
                 used_count, reject_count);
        if (failures == 0)
            $display("[coeff_rejection_test] OK");
        else
            $display("[coeff_rejection_test] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/crt_pkg.sv
sv/crt_if.sv
sv/crt_eval.sv
sv/coeff_rejection_test.sv
verif/crt_verdict_checker.sv
verif/tb.sv
